// File: design/gpthv_pkg.sv
// Package with the constants, types and CRC step of the GPT header validator.
`timescale 1ns / 1ps

package gpthv_pkg;

    // Sector size in bytes; a power of two so that sector counts come from shifts.
    localparam int SECTOR_BYTES = 512;
    localparam int MAX_ENTRIES  = 128;

    localparam int SECTOR_LOG2  = $clog2(SECTOR_BYTES);
    // Byte counter saturates at SECTOR_BYTES + 1.
    localparam int POS_W        = $clog2(SECTOR_BYTES + 2);
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int BYTES_W      = CNT_W + SECTOR_LOG2;
    localparam int SECS_W       = CNT_W + 1;

    localparam int LBA_W        = 64;
    localparam int WORD_W       = 32;
    localparam int CFG_W        = 64;

    localparam logic [WORD_W-1:0] CRC_POLY = 32'hedb88320;
    localparam logic [WORD_W-1:0] CRC_INIT = 32'hffffffff;

    // Header byte offsets.
    localparam int SIG_LEN      = 12;
    localparam int OFS_SIZE     = 12;
    localparam int OFS_HCRC     = 16;
    localparam int OFS_RSVD     = 20;
    localparam int OFS_LBA      = 24;
    localparam int OFS_GUID     = 56;
    localparam int OFS_ENTLBA   = 72;
    localparam int OFS_CSC      = 80;
    localparam int HDR_MIN      = 92;

    localparam int LBA_N        = 5;
    localparam int GUID_N       = 2;
    localparam int CSC_N        = 3;

    // Smallest legal entry size is 128 bytes.
    localparam int ENT_MIN_LOG2 = 7;

    // "EFI PART" followed by revision 1.0, byte 0 in the low bits.
    localparam logic [8*SIG_LEN-1:0] SIGNATURE = 96'h00010000_54524150_20494645;

    typedef logic [LBA_W-1:0]  t_lba;
    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [0:0] {
        CFG_MEDIA_SECTORS = 1'b0,
        CFG_HEADER_POS    = 1'b1
    } t_cfg_idx;

    // Start offset of LBA field f: four consecutive 64-bit fields, then the entry array LBA.
    function automatic int lba_offset(input int f);
        return (f < 4) ? (OFS_LBA + 8 * f) : OFS_ENTLBA;
    endfunction

    // One byte of a reflected CRC-32.
    function automatic t_word crc_byte(input t_word acc, input logic [7:0] b);
        t_word c;
        c = acc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage

// File: design/gpthv_in_if.sv
// Byte stream channel into the GPT header validator.
`timescale 1ns / 1ps

interface gpthv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// File: design/gpthv_out_if.sv
// Result channel out of the GPT header validator.
`timescale 1ns / 1ps

interface gpthv_out_if;
    logic              valid;
    logic              ready;
    logic              header_ok;
    gpthv_pkg::t_lba   current_lba;
    gpthv_pkg::t_lba   alternate_lba;
    gpthv_pkg::t_lba   first_usable_lba;
    gpthv_pkg::t_lba   last_usable_lba;
    gpthv_pkg::t_lba   entries_lba;
    gpthv_pkg::t_word  entry_total;
    gpthv_pkg::t_word  entry_bytes;
    gpthv_pkg::t_word  entries_crc;
    gpthv_pkg::t_lba   guid_low;
    gpthv_pkg::t_lba   guid_high;

    modport source (output valid, header_ok, current_lba, alternate_lba, first_usable_lba,
                    last_usable_lba, entries_lba, entry_total, entry_bytes, entries_crc,
                    guid_low, guid_high, input ready);
    modport sink   (input valid, header_ok, current_lba, alternate_lba, first_usable_lba,
                    last_usable_lba, entries_lba, entry_total, entry_bytes, entries_crc,
                    guid_low, guid_high, output ready);
endinterface

// File: design/gpt_header_validator.sv
// Top level of the streaming GPT header validator.
//
//   channel   direction  payload                                 transfer when
//   i_in      in         data_byte, last_byte                    valid & ready
//   o_out     out        header_ok, parsed LBAs, counts, GUID    valid & ready
//   i_cfg_*   in         index, 64-bit data                      i_cfg_we
//
// One byte is taken per cycle while ready; CRC step and field capture finish in that cycle.
// The result is registered at the transfer of the final byte and offered on the next cycle.
// A new sector may start right behind it; i_in.ready drops only while a result waits and
// o_out.ready is low. Reset is synchronous: it restarts the sector, drops a pending
// result and sets the medium size to 0 and the header position to 1.
`timescale 1ns / 1ps

module gpt_header_validator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  gpthv_pkg::t_cfg_idx          i_cfg_idx,
    input  logic [gpthv_pkg::CFG_W-1:0]  i_cfg_wdata,
    gpthv_in_if.sink                     i_in,
    gpthv_out_if.source                  o_out
);
    import gpthv_pkg::*;

    // Configuration.
    t_lba r_media;
    t_lba r_hpos;

    // Per-sector accumulation.
    logic [POS_W-1:0] r_pos,      n_pos;
    t_word            r_crc,      n_crc;
    t_word            r_hdr_size, n_hdr_size;
    t_word            r_hdr_crc,  n_hdr_crc;
    logic             r_early,    n_early;
    t_lba             r_lba  [LBA_N],  n_lba  [LBA_N];
    t_lba             r_guid [GUID_N], n_guid [GUID_N];
    t_word            r_csc  [CSC_N],  n_csc  [CSC_N];

    // Result register.
    logic             r_o_valid;
    logic             r_o_ok;
    t_lba             r_o_lba  [LBA_N];
    t_lba             r_o_guid [GUID_N];
    t_word            r_o_csc  [CSC_N];

    logic             in_xfer;
    logic             final_xfer;
    logic             in_range;
    logic [7:0]       fed;
    t_word            crc_step;

    logic             h_is_one;
    t_lba             m_minus1;
    logic             early;
    logic             cnt_ok;
    logic             esz_ok;
    logic [BYTES_W-1:0] tbl_bytes;
    logic [BYTES_W:0]   bytes_up;
    logic [SECS_W-1:0]  secs;
    t_lba             secs_ext;
    t_lba             end_sum;
    logic             place_ok;
    logic             layout_ok;

    assign i_in.ready = !r_o_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign final_xfer = in_xfer && i_in.last_byte;

    // Byte capture and CRC step.
    always_comb begin
        n_pos      = r_pos;
        n_hdr_size = r_hdr_size;
        n_hdr_crc  = r_hdr_crc;
        n_early    = r_early;
        n_lba      = r_lba;
        n_guid     = r_guid;
        n_csc      = r_csc;
        fed        = i_in.data_byte;
        crc_step   = r_crc;
        in_range   = r_pos < POS_W'(SECTOR_BYTES);

        if (in_range) begin
            for (int k = 0; k < SIG_LEN; k++) begin
                if (r_pos == POS_W'(k) && i_in.data_byte != SIGNATURE[8*k +: 8]) begin
                    n_early = 1'b1;
                end
            end
            for (int k = 0; k < 4; k++) begin
                if (r_pos == POS_W'(OFS_SIZE + k)) begin
                    n_hdr_size[8*k +: 8] = i_in.data_byte;
                end
                // The stored CRC bytes enter the CRC as zeros.
                if (r_pos == POS_W'(OFS_HCRC + k)) begin
                    n_hdr_crc[8*k +: 8] = i_in.data_byte;
                    fed = '0;
                end
                if (r_pos == POS_W'(OFS_RSVD + k) && i_in.data_byte != '0) begin
                    n_early = 1'b1;
                end
            end
            for (int f = 0; f < LBA_N; f++) begin
                for (int k = 0; k < 8; k++) begin
                    if (r_pos == POS_W'(lba_offset(f) + k)) begin
                        n_lba[f][8*k +: 8] = i_in.data_byte;
                    end
                end
            end
            for (int g = 0; g < GUID_N; g++) begin
                for (int k = 0; k < 8; k++) begin
                    if (r_pos == POS_W'(OFS_GUID + 8 * g + k)) begin
                        n_guid[g][8*k +: 8] = i_in.data_byte;
                    end
                end
            end
            for (int c = 0; c < CSC_N; c++) begin
                for (int k = 0; k < 4; k++) begin
                    if (r_pos == POS_W'(OFS_CSC + 4 * c + k)) begin
                        n_csc[c][8*k +: 8] = i_in.data_byte;
                    end
                end
            end
            if (r_pos < POS_W'(OFS_HCRC) || WORD_W'(r_pos) < r_hdr_size) begin
                crc_step = crc_byte(r_crc, fed);
            end
        end

        n_crc = crc_step;
        if (i_in.last_byte) begin
            n_pos   = '0;
            n_crc   = CRC_INIT;
            n_early = 1'b0;
        end else if (r_pos < POS_W'(SECTOR_BYTES + 1)) begin
            n_pos = r_pos + 1'b1;
        end
    end

    // Final checks, evaluated on the cycle that the last byte transfers.
    always_comb begin
        h_is_one = r_hpos == 64'd1;
        m_minus1 = r_media - 64'd1;

        early = r_early
            || r_pos != POS_W'(SECTOR_BYTES - 1)
            || r_media < 64'd3
            || (!h_is_one && r_hpos != m_minus1)
            || r_hdr_size < WORD_W'(HDR_MIN)
            || r_hdr_size > WORD_W'(SECTOR_BYTES)
            || (crc_step ^ CRC_INIT) != r_hdr_crc;

        cnt_ok = r_csc[0] != '0 && r_csc[0] <= WORD_W'(MAX_ENTRIES);

        // Legal entry sizes are powers of two, so the array size is a shift of the count.
        esz_ok    = 1'b0;
        tbl_bytes = '0;
        for (int k = ENT_MIN_LOG2; k <= SECTOR_LOG2; k++) begin
            if (r_csc[1] == (WORD_W'(1) << k)) begin
                esz_ok    = 1'b1;
                tbl_bytes = BYTES_W'(r_csc[0][CNT_W-1:0]) << k;
            end
        end
        bytes_up = {1'b0, tbl_bytes} + (BYTES_W + 1)'(SECTOR_BYTES - 1);
        secs     = bytes_up[BYTES_W:SECTOR_LOG2];
        secs_ext = LBA_W'(secs);
        end_sum  = r_lba[4] + secs_ext;

        if (h_is_one) begin
            place_ok = r_lba[4] > r_hpos && end_sum <= r_lba[2];
        end else begin
            place_ok = r_lba[4] > r_lba[3] && end_sum <= r_hpos;
        end

        layout_ok = r_lba[0] == r_hpos
            && r_lba[1] == (h_is_one ? m_minus1 : 64'd1)
            && r_lba[2] <= r_lba[3]
            && r_lba[3] < r_media
            && cnt_ok
            && esz_ok
            && r_lba[4] < r_media
            && secs != '0
            && secs_ext <= r_media - r_lba[4]
            && place_ok;
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_media   <= '0;
            r_hpos    <= 64'd1;
            r_pos     <= '0;
            r_crc     <= CRC_INIT;
            r_early   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MEDIA_SECTORS: r_media <= i_cfg_wdata;
                    CFG_HEADER_POS:    r_hpos  <= i_cfg_wdata;
                endcase
            end
            if (in_xfer) begin
                r_pos   <= n_pos;
                r_crc   <= n_crc;
                r_early <= n_early;
            end
            if (final_xfer) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Field capture and result payload; every field of a good sector is rewritten.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_hdr_size <= n_hdr_size;
            r_hdr_crc  <= n_hdr_crc;
            r_lba      <= n_lba;
            r_guid     <= n_guid;
            r_csc      <= n_csc;
        end
        if (final_xfer) begin
            r_o_ok <= !early && layout_ok;
            for (int f = 0; f < LBA_N; f++) begin
                r_o_lba[f] <= early ? '0 : r_lba[f];
            end
            for (int g = 0; g < GUID_N; g++) begin
                r_o_guid[g] <= early ? '0 : r_guid[g];
            end
            for (int c = 0; c < CSC_N; c++) begin
                r_o_csc[c] <= early ? '0 : r_csc[c];
            end
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.header_ok        = r_o_ok;
    assign o_out.current_lba      = r_o_lba[0];
    assign o_out.alternate_lba    = r_o_lba[1];
    assign o_out.first_usable_lba = r_o_lba[2];
    assign o_out.last_usable_lba  = r_o_lba[3];
    assign o_out.entries_lba      = r_o_lba[4];
    assign o_out.entry_total      = r_o_csc[0];
    assign o_out.entry_bytes      = r_o_csc[1];
    assign o_out.entries_crc      = r_o_csc[2];
    assign o_out.guid_low         = r_o_guid[0];
    assign o_out.guid_high        = r_o_guid[1];

endmodule

// File: verif/gpt_header_validator_test.sv
// Self-checking testbench for the streaming GPT header validator.
`timescale 1ns / 1ps

module gpt_header_validator_test;
    import gpthv_pkg::*;

    localparam int SECTOR_LEN  = 512;
    localparam int ENTRY_CAP   = 128;
    localparam int HDR_FLOOR   = 92;
    localparam int HOLD_CYCLES = 1500;
    localparam int CYCLE_LIMIT = 100000;
    localparam logic [31:0] POLY_REFLECTED = 32'hedb88320;
    // "EFI PART" and revision 1.0, byte 0 in the low bits.
    localparam logic [95:0] SIG_TEXT = 96'h0001_0000_5452_4150_2049_4645;

    typedef struct packed {
        logic  ok;
        t_lba  cur_lba;
        t_lba  alt_lba;
        t_lba  first_lba;
        t_lba  last_lba;
        t_lba  ent_lba;
        t_word cnt;
        t_word esz;
        t_word ecrc;
        t_lba  guid_lo;
        t_lba  guid_hi;
    } t_verdict;

    typedef enum {
        SK_GOOD, SK_MIN_HDR, SK_MAX_HDR, SK_BAD_SIG, SK_BAD_REV, SK_HDR_SHORT,
        SK_HDR_LONG, SK_RSVD, SK_BAD_CRC, SK_LEN_ONE, SK_LEN_511, SK_LEN_LONG,
        SK_NO_ENTRIES, SK_ODD_ESZ, SK_WRONG_CUR, SK_ALL_ONES
    } t_sector_kind;

    typedef struct {
        t_sector_kind kind;
        logic [63:0]  media;
        logic [63:0]  hpos;
        bit           typed;
    } t_plan_row;

    // Rows marked typed expect the all-zero result of an early failure.
    t_plan_row directed_plan [3] = '{
        '{SK_LEN_ONE,    64'd0,     64'd1,     1'b1},
        '{SK_GOOD,       64'd1000,  64'd1,     1'b0},
        '{SK_LEN_ONE,    64'd2,     64'd1,     1'b1}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    t_cfg_idx            i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_wdata;

    gpthv_in_if  in_ch ();
    gpthv_out_if out_ch ();

    gpt_header_validator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #10 i_clk = ~i_clk;

    // Predictor copy of the configuration and of the per-sector state.
    logic [63:0] cfg_media = 64'd0;
    logic [63:0] cfg_hpos  = 64'd1;
    int          hdr_pos       = 0;
    logic [31:0] hdr_crc       = '1;
    logic [31:0] hdr_size      = '0;
    logic [31:0] hdr_crc_field = '0;
    bit          hdr_broken    = 1'b0;
    logic [63:0] hdr_lba  [5];
    logic [63:0] hdr_guid [2];
    logic [31:0] hdr_words [3];

    t_verdict pending_verdicts [$];
    t_verdict typed_verdicts [int];
    int       sectors_sent   = 0;
    int       sectors_closed = 0;
    int       errors         = 0;
    int       cycle_count    = 0;
    int       tx_max_gap     = 0;
    int       rx_max_gap     = 0;
    bit       hold_req       = 1'b0;

    logic [7:0] sec_buf [SECTOR_LEN];

    function automatic logic [31:0] crc_step(logic [31:0] acc, logic [7:0] b);
        for (int i = 0; i < 8; i++) begin
            if (acc[0] ^ b[i]) acc = (acc >> 1) ^ POLY_REFLECTED;
            else acc = acc >> 1;
        end
        return acc;
    endfunction

    function automatic void clear_tracker();
        hdr_pos       = 0;
        hdr_crc       = '1;
        hdr_size      = '0;
        hdr_crc_field = '0;
        hdr_broken    = 1'b0;
        for (int k = 0; k < 5; k++) hdr_lba[k] = '0;
        for (int k = 0; k < 3; k++) hdr_words[k] = '0;
        hdr_guid[0] = '0;
        hdr_guid[1] = '0;
    endfunction

    function automatic bit layout_sound();
        logic [63:0] m, h, ent, bytes, secs;
        logic [31:0] cnt, esz;
        m   = cfg_media;
        h   = cfg_hpos;
        ent = hdr_lba[4];
        cnt = hdr_words[0];
        esz = hdr_words[1];
        if (hdr_lba[0] != h || hdr_lba[1] != ((h == 64'd1) ? m - 64'd1 : 64'd1)) return 1'b0;
        if (hdr_lba[2] > hdr_lba[3] || hdr_lba[3] >= m) return 1'b0;
        if (cnt == 0 || cnt > ENTRY_CAP) return 1'b0;
        if (esz < 128 || esz > SECTOR_LEN || (esz & (esz - 32'd1)) != 0) return 1'b0;
        bytes = {32'd0, cnt} * {32'd0, esz};
        secs  = (bytes + SECTOR_LEN - 1) / SECTOR_LEN;
        if (ent >= m || secs == 0 || secs > m - ent) return 1'b0;
        if (h == 64'd1) begin
            if (ent <= h || ent + secs > hdr_lba[2]) return 1'b0;
        end else begin
            if (ent <= hdr_lba[3] || ent + secs > h) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void absorb_byte(logic [7:0] b, logic fin);
        logic [7:0] fed;
        t_verdict   v;
        bit         early;
        int         p;
        p = hdr_pos;
        if (p < SECTOR_LEN) begin
            fed = b;
            if (p < 12) begin
                if (b != SIG_TEXT[8*p +: 8]) hdr_broken = 1'b1;
            end else if (p < 16) begin
                hdr_size[8*(p-12) +: 8] = b;
            end else if (p < 20) begin
                // The stored CRC field enters the CRC as zeros.
                hdr_crc_field[8*(p-16) +: 8] = b;
                fed = 8'd0;
            end else if (p < 24) begin
                if (b != 8'd0) hdr_broken = 1'b1;
            end else if (p < 56) begin
                hdr_lba[(p-24) >> 3][8*((p-24) & 7) +: 8] = b;
            end else if (p < 72) begin
                hdr_guid[(p-56) >> 3][8*((p-56) & 7) +: 8] = b;
            end else if (p < 80) begin
                hdr_lba[4][8*(p-72) +: 8] = b;
            end else if (p < HDR_FLOOR) begin
                hdr_words[(p-80) >> 2][8*((p-80) & 3) +: 8] = b;
            end
            if (p < 16 || p < hdr_size) hdr_crc = crc_step(hdr_crc, fed);
        end
        if (!fin) begin
            if (p < SECTOR_LEN + 1) hdr_pos = p + 1;
            return;
        end
        early = hdr_broken || p != SECTOR_LEN - 1 || cfg_media < 3
            || (cfg_hpos != 64'd1 && cfg_hpos != cfg_media - 64'd1)
            || hdr_size < HDR_FLOOR || hdr_size > SECTOR_LEN
            || (~hdr_crc) != hdr_crc_field;
        v = '0;
        if (!early) begin
            v.ok        = layout_sound();
            v.cur_lba   = hdr_lba[0];
            v.alt_lba   = hdr_lba[1];
            v.first_lba = hdr_lba[2];
            v.last_lba  = hdr_lba[3];
            v.ent_lba   = hdr_lba[4];
            v.cnt       = hdr_words[0];
            v.esz       = hdr_words[1];
            v.ecrc      = hdr_words[2];
            v.guid_lo   = hdr_guid[0];
            v.guid_hi   = hdr_guid[1];
        end
        if (typed_verdicts.exists(sectors_closed)) v = typed_verdicts[sectors_closed];
        pending_verdicts.push_back(v);
        sectors_closed++;
        clear_tracker();
    endfunction

    task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : stream_tap
        t_verdict want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: result transfer with no header pending", $time);
                    errors++;
                end else begin
                    want = pending_verdicts.pop_front();
                    check_field("header_ok", want.ok, out_ch.header_ok);
                    check_field("current_lba", want.cur_lba, out_ch.current_lba);
                    check_field("alternate_lba", want.alt_lba, out_ch.alternate_lba);
                    check_field("first_usable_lba", want.first_lba, out_ch.first_usable_lba);
                    check_field("last_usable_lba", want.last_lba, out_ch.last_usable_lba);
                    check_field("entries_lba", want.ent_lba, out_ch.entries_lba);
                    check_field("entry_total", want.cnt, out_ch.entry_total);
                    check_field("entry_bytes", want.esz, out_ch.entry_bytes);
                    check_field("entries_crc", want.ecrc, out_ch.entries_crc);
                    check_field("guid_low", want.guid_lo, out_ch.guid_low);
                    check_field("guid_high", want.guid_hi, out_ch.guid_high);
                end
            end
            if (in_ch.valid && in_ch.ready) absorb_byte(in_ch.data_byte, in_ch.last_byte);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("gpt_header_validator regression: fail");
            $finish;
        end
    end

    // Result side: random stalls, stretches without stalls, and one long hold.
    initial begin : result_sink
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                gap = (rx_max_gap == 0) ? 0 : $urandom_range(0, rx_max_gap);
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            rx_max_gap = ($urandom_range(0, 2) == 0) ? 0 : 6;
        end
    end

    task automatic put_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= fin;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_sector(input int len);
        for (int i = 0; i < len; i++)
            put_byte((i < SECTOR_LEN) ? sec_buf[i] : 8'($urandom_range(0, 255)), i == len - 1);
        sectors_sent++;
    endtask

    // Waits until every result has been taken and the block has gone quiet.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [63:0] m, input logic [63:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_MEDIA_SECTORS;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_HEADER_POS;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_media = m;
        cfg_hpos  = h;
    endtask

    function automatic void put_le(input int ofs, input int n, input logic [63:0] v);
        for (int k = 0; k < n; k++) sec_buf[ofs + k] = v[8*k +: 8];
    endfunction

    function automatic void seal(input int hsize);
        logic [31:0] c;
        int n;
        n = (hsize > SECTOR_LEN) ? SECTOR_LEN : hsize;
        if (n < 16) n = 16;
        c = '1;
        for (int i = 0; i < n; i++)
            c = crc_step(c, (i >= 16 && i < 20) ? 8'd0 : sec_buf[i]);
        put_le(16, 4, {32'd0, ~c});
    endfunction

    // Builds a header with a sound layout; an impossible setting falls back to a
    // 1000-sector medium read at LBA 1, so its layout fails against the real one.
    task automatic build_header(input logic [63:0] m, input logic [63:0] h, input int hsize,
                                input logic [31:0] cnt, input logic [31:0] esz);
        logic [63:0] secs, ent, first_lba, last_lba, alt;
        if (!(m >= 400 && (h == 64'd1 || h == m - 64'd1))) begin
            m = 64'd1000;
            h = 64'd1;
        end
        for (int i = 0; i < SECTOR_LEN; i++) sec_buf[i] = $urandom_range(0, 255);
        for (int i = 0; i < 12; i++) sec_buf[i] = SIG_TEXT[8*i +: 8];
        secs = ({32'd0, cnt} * {32'd0, esz} + SECTOR_LEN - 1) / SECTOR_LEN;
        if (h == 64'd1) begin
            ent       = 64'd2 + $urandom_range(0, 3);
            first_lba = ent + secs + $urandom_range(0, 10);
            last_lba  = m - 64'd2 - $urandom_range(0, 60);
            alt       = m - 64'd1;
        end else begin
            ent       = h - secs - $urandom_range(0, 3);
            last_lba  = ent - 64'd1 - $urandom_range(0, 3);
            first_lba = 64'd2 + $urandom_range(0, 32);
            alt       = 64'd1;
        end
        put_le(12, 4, hsize);
        put_le(20, 4, 64'd0);
        put_le(24, 8, h);
        put_le(32, 8, alt);
        put_le(40, 8, first_lba);
        put_le(48, 8, last_lba);
        put_le(72, 8, ent);
        put_le(80, 4, cnt);
        put_le(84, 4, esz);
    endtask

    task automatic shape_directed(input t_sector_kind kind, output int len);
        int hsize;
        logic [31:0] cnt, esz;
        hsize = HDR_FLOOR;
        cnt   = $urandom_range(1, ENTRY_CAP);
        esz   = 128;
        len   = SECTOR_LEN;
        case (kind)
            SK_MIN_HDR:    cnt = ENTRY_CAP;
            SK_MAX_HDR: begin
                hsize = SECTOR_LEN;
                cnt   = 1;
                esz   = SECTOR_LEN;
            end
            SK_HDR_SHORT:  hsize = HDR_FLOOR - 1;
            SK_HDR_LONG:   hsize = SECTOR_LEN + 1;
            SK_NO_ENTRIES: cnt = 0;
            SK_ODD_ESZ:    esz = 192;
            default: ;
        endcase
        build_header(cfg_media, cfg_hpos, hsize, cnt, esz);
        case (kind)
            SK_RSVD:      sec_buf[21] = 8'h80;
            SK_WRONG_CUR: put_le(24, 8, cfg_hpos + 64'd1);
            SK_ALL_ONES:  for (int i = 24; i < HDR_FLOOR; i++) sec_buf[i] = 8'hff;
            default: ;
        endcase
        seal(hsize);
        case (kind)
            SK_BAD_SIG: sec_buf[0]  = sec_buf[0] ^ 8'h01;
            SK_BAD_REV: sec_buf[10] = 8'h02;
            SK_BAD_CRC: sec_buf[16] = sec_buf[16] ^ 8'h01;
            SK_LEN_ONE: len = 1;
            SK_LEN_511: len = SECTOR_LEN - 1;
            SK_LEN_LONG: len = SECTOR_LEN + 8;
            default: ;
        endcase
    endtask

    // Mostly well-formed headers with random content, plus layout edits,
    // corrupted bytes and plain noise. Only a full sector runs to its end;
    // the others stop after a few bytes.
    task automatic compose_random_sector(input bit full, output int len);
        int hsize, pick, ofs;
        logic [31:0] cnt, esz;
        hsize = ($urandom_range(0, 3) == 0) ? $urandom_range(HDR_FLOOR, SECTOR_LEN) : HDR_FLOOR;
        cnt   = $urandom_range(1, ENTRY_CAP);
        case ($urandom_range(0, 2))
            0: esz = 128;
            1: esz = 256;
            default: esz = 512;
        endcase
        build_header(cfg_media, cfg_hpos, hsize, cnt, esz);
        pick = $urandom_range(0, 99);
        if (pick >= 55 && pick < 75) begin
            ofs = $urandom_range(24, HDR_FLOOR - 1);
            sec_buf[ofs] = sec_buf[ofs] ^ 8'($urandom_range(1, 255));
        end
        seal(hsize);
        if (pick >= 95) begin
            for (int i = 0; i < SECTOR_LEN; i++) sec_buf[i] = $urandom_range(0, 255);
        end else if (pick >= 75) begin
            ofs = $urandom_range(0, SECTOR_LEN - 1);
            sec_buf[ofs] = sec_buf[ofs] ^ 8'($urandom_range(1, 255));
        end
        if (full) begin
            len = ($urandom_range(0, 3) == 0) ? SECTOR_LEN + $urandom_range(1, 8) : SECTOR_LEN;
        end else begin
            len = $urandom_range(1, 19);
        end
    endtask

    initial begin
        int len;
        logic [63:0] m, h;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_MEDIA_SECTORS;
        i_cfg_wdata     <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.last_byte <= 1'b0;
        out_ch.ready    <= 1'b0;
        for (int k = 0; k < 5; k++) hdr_lba[k] = '0;
        for (int k = 0; k < 3; k++) hdr_words[k] = '0;
        hdr_guid[0] = '0;
        hdr_guid[1] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[r]) begin
            if (directed_plan[r].media !== cfg_media || directed_plan[r].hpos !== cfg_hpos) begin
                settle();
                set_config(directed_plan[r].media, directed_plan[r].hpos);
            end
            if (directed_plan[r].typed) typed_verdicts[sectors_sent] = '0;
            shape_directed(directed_plan[r].kind, len);
            tx_max_gap = ($urandom_range(0, 1) == 0) ? 0 : 6;
            send_sector(len);
        end

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1: begin
                    m = {$urandom | 32'h8000_0000, $urandom};
                    h = ($urandom_range(0, 1) == 0) ? 64'd1 : m - 64'd1;
                end
                2: begin
                    m = $urandom_range(0, 2);
                    h = 64'd1;
                end
                3: begin
                    m = $urandom_range(400, 100000);
                    h = 64'd1;
                end
                default: begin
                    m = '1;
                    h = m - 64'd1;
                end
            endcase
            settle();
            set_config(m, h);
            // Back-to-back bytes while the result side holds off, so the block
            // has to stall its input.
            if (ph == 3) hold_req = 1'b1;
            for (int k = 0; k < 8; k++) begin
                tx_max_gap = (ph == 3 || $urandom_range(0, 1) == 0) ? 0 : 6;
                compose_random_sector(ph == 0 && k == 0, len);
                send_sector(len);
            end
        end

        settle();
        repeat (6) @(posedge i_clk);
        if (errors == 0) begin
            $display("gpt_header_validator regression: pass");
        end else begin
            $display("gpt_header_validator regression: fail");
        end
        $finish;
    end

endmodule
